[sv/calendar_date_advance_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the calendar date advance core
// Each macro expands to a concurrent assertion clocked on clk, or to nothing
// when the design is built for synthesis.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ADVANCE_CORE_DEFINES_SVH
`define CALENDAR_DATE_ADVANCE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while out of reset
`define CDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included
`define CDA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDA_ASSERT(lbl, prop, msg)
`define CDA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/cda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_pkg
// Shared constants, controller/datapath interface types and calendar
// helper functions for the date advance core.
// ----------------------------------------------------------------------------
package cda_pkg;

    localparam int CDA_COUNT_BITS = 16;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] DAY_FIRST = 5'd1;
    localparam logic [4:0] DAYS_31   = 5'd31;
    localparam logic [4:0] DAYS_30   = 5'd30;
    localparam logic [4:0] DAYS_29   = 5'd29;
    localparam logic [4:0] DAYS_28   = 5'd28;

    localparam int         YLEN_BITS        = 9;
    localparam logic [8:0] DAYS_LEAP_YEAR   = 9'd366;
    localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;

    // y is a multiple of 25 iff y * inv(25) mod 2^16 <= floor(65535 / 25)
    localparam logic [15:0] INV25_MOD16   = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT   = 16'd2621;

    typedef struct packed {
        logic load;       // take the accepted transaction into the datapath
        logic calc_leap;  // refresh the leap flag from the current year
        logic step;       // one calendar step toward the target date
        logic capture;    // move the finished date into the output register
    } cda_cmd_t;

    typedef struct packed {
        logic count_zero; // no days left to add
        logic year_wrap;  // the pending step changes the year
    } cda_sts_t;

    // Leap: divisible by 4 and not by 100, or by 400.
    // With y % 4 == 0: y % 100 == 0 iff 25 | y, and y % 400 == 0 iff also 16 | y.
    function automatic logic is_leap(input logic [15:0] y);
        logic [31:0] prod;
        logic        div25;
        prod  = 32'(y) * 32'(INV25_MOD16);
        div25 = (prod[15:0] <= DIV25_LIMIT);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m) inside
            MONTH_FEB:                               len = leap ? DAYS_29 : DAYS_28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_30;
            default:                                 len = DAYS_31;
        endcase
        return len;
    endfunction

endpackage

[sv/cda_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_ctrl
// Sequencer for the date advance core: accepts a transaction, walks the
// datapath through leap refresh and calendar steps, and hands the result
// to the output register.
// ----------------------------------------------------------------------------
`include "calendar_date_advance_core_defines.svh"

module cda_ctrl
    import cda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  cda_sts_t sts,
    output cda_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LEAP = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.load      = (state_reg == ST_IDLE) && in_valid;
        cmd.calc_leap = (state_reg == ST_LEAP);
        cmd.step      = (state_reg == ST_RUN) && !sts.count_zero;
        cmd.capture   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_LEAP;
            end
            ST_LEAP:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (sts.count_zero)
                    state_next = ST_DONE;
                else if (sts.year_wrap)
                    state_next = ST_LEAP;
            end
            ST_DONE:
            begin
                if (cmd.capture)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.capture)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    `CDA_ASSERT(a_capture_no_overwrite, cmd.capture && out_valid_reg |-> out_ready, "result overwritten before transaction")
    `CDA_ASSERT(a_capture_sets_valid, cmd.capture |=> out_valid_reg, "captured result not presented")
    `CDA_ASSERT(a_leap_after_wrap, cmd.step && sts.year_wrap |=> cmd.calc_leap, "year changed without leap refresh")

endmodule

[sv/cda_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_datapath
// Date registers, remaining day count, leap flag and output register.
// Step commands perform one calendar step per cycle, paused by leap refreshes.
// ----------------------------------------------------------------------------
`include "calendar_date_advance_core_defines.svh"

module cda_datapath
    import cda_pkg::*;
#(
    parameter int COUNT_BITS = CDA_COUNT_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cda_cmd_t    cmd,
    output cda_sts_t    sts,
    input  logic        mode,
    input  logic [4:0]  new_day,
    input  logic [3:0]  new_month,
    input  logic [15:0] new_year,
    input  logic [15:0] day_count,
    output logic [4:0]  day,
    output logic [3:0]  month,
    output logic [15:0] year,
    output logic        leap_year
);

    localparam int CMP_BITS = (COUNT_BITS > YLEN_BITS) ? COUNT_BITS : YLEN_BITS;

    logic [4:0]            day_reg, day_next;
    logic [3:0]            month_reg, month_next;
    logic [15:0]           year_reg, year_next;
    logic                  leap_reg, leap_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic [4:0]            day_out_reg;
    logic [3:0]            month_out_reg;
    logic [15:0]           year_out_reg;
    logic                  leap_out_reg;

    logic [4:0]            load_day;
    logic [3:0]            load_month;
    logic [31:0]           count_ext;
    logic [8:0]            ylen;
    logic [4:0]            mlen;
    logic [4:0]            room;
    logic [CMP_BITS-1:0]   n_cmp;
    logic [CMP_BITS-1:0]   ylen_cmp;
    logic [CMP_BITS-1:0]   room_cmp;
    logic                  year_start;
    logic                  skip_year;
    logic                  day_in;
    logic                  short_step;

    always_comb
    begin
        // Clamp a zero day and an out-of-range month on load
        load_day = (new_day == 5'd0) ? DAY_FIRST : new_day;
        if (new_month == 4'd0)
            load_month = MONTH_JAN;
        else if (new_month > MONTH_DEC)
            load_month = MONTH_DEC;
        else
            load_month = new_month;

        count_ext  = 32'(day_count);
        ylen       = leap_reg ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
        mlen       = month_len(month_reg, leap_reg);
        room       = mlen - day_reg;
        n_cmp      = CMP_BITS'(count_reg);
        ylen_cmp   = CMP_BITS'(ylen);
        room_cmp   = CMP_BITS'(room);
        year_start = (day_reg == DAY_FIRST) && (month_reg == MONTH_JAN);
        skip_year  = year_start && (n_cmp >= ylen_cmp);
        day_in     = (day_reg < mlen);
        short_step = (n_cmp < room_cmp);
    end

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        leap_next  = leap_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            if (mode == MODE_LOAD)
            begin
                day_next   = load_day;
                month_next = load_month;
                year_next  = new_year;
                count_next = '0;
            end
            else
            begin
                count_next = count_ext[COUNT_BITS-1:0];
            end
        end
        else if (cmd.calc_leap)
        begin
            leap_next = is_leap(year_reg);
        end
        else if (cmd.step)
        begin
            if (skip_year)
            begin
                // Skip a whole year from January 1st
                count_next = count_reg - COUNT_BITS'(ylen);
                year_next  = year_reg + 16'd1;
            end
            else if (day_in)
            begin
                if (short_step)
                begin
                    day_next   = day_reg + n_cmp[4:0];
                    count_next = '0;
                end
                else
                begin
                    day_next   = day_reg + room;
                    count_next = count_reg - COUNT_BITS'(room);
                end
            end
            else
            begin
                // At or past month end: roll to the 1st of the next month
                day_next   = DAY_FIRST;
                count_next = count_reg - COUNT_BITS'(1);
                if (month_reg >= MONTH_DEC)
                begin
                    month_next = MONTH_JAN;
                    year_next  = year_reg + 16'd1;
                end
                else
                begin
                    month_next = month_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg   <= DAY_FIRST;
            month_reg <= MONTH_JAN;
            year_reg  <= 16'd0;
            leap_reg  <= 1'b1;
            count_reg <= '0;
        end
        else
        begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            leap_reg  <= leap_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            day_out_reg   <= day_reg;
            month_out_reg <= month_reg;
            year_out_reg  <= year_reg;
            leap_out_reg  <= leap_reg;
        end
    end

    always_comb
    begin
        sts.count_zero = (count_reg == '0);
        sts.year_wrap  = skip_year || (!day_in && (month_reg >= MONTH_DEC));
    end

    assign day       = day_out_reg;
    assign month     = month_out_reg;
    assign year      = year_out_reg;
    assign leap_year = leap_out_reg;

    `CDA_ASSERT(a_month_range, (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC), "month out of range")
    `CDA_ASSERT(a_day_nonzero, day_reg != 5'd0, "day register holds zero")
    `CDA_ASSERT(a_count_no_grow, !cmd.load |=> count_reg <= $past(count_reg), "day count grew without a load")

endmodule

[sv/calendar_date_advance_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_advance_core
// Gregorian date register with load and advance-by-N-days.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): mode = 0 loads new_day/new_month/
//   new_year (day 0 taken as 1, month clamped to 1..12); mode = 1 adds
//   day_count (low COUNT_BITS bits) to the held date.
//   Output channel (out_valid/out_ready): one result per input transaction,
//   the date after it and the leap flag of its year.
//   A load or a zero count passes from acceptance through a leap refresh,
//   the run state and the done state, where the result is registered. An
//   advance adds a run-state step per calendar step (a partial month, a
//   month rollover or a whole year skipped from January 1st) and one more
//   leap refresh per year change. The single step unit walks the date one
//   step per cycle, paused by each leap refresh.
//   A new transaction is taken only once the previous one is finished; it
//   may be accepted while the previous result still waits in the output
//   register. If the receiver stalls, the finished date waits until the
//   output register frees up.
//   Reset sets the date to January 1st of year 0 and empties the output.
// ----------------------------------------------------------------------------
module calendar_date_advance_core
    import cda_pkg::*;
#(
    parameter int COUNT_BITS = CDA_COUNT_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [4:0]  new_day,
    input  logic [3:0]  new_month,
    input  logic [15:0] new_year,
    input  logic [15:0] day_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  day,
    output logic [3:0]  month,
    output logic [15:0] year,
    output logic        leap_year
);

    cda_cmd_t cmd;
    cda_sts_t sts;

    cda_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cda_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .mode      (mode),
        .new_day   (new_day),
        .new_month (new_month),
        .new_year  (new_year),
        .day_count (day_count),
        .day       (day),
        .month     (month),
        .year      (year),
        .leap_year (leap_year)
    );

endmodule

[verif/calendar_date_advance_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_advance_core_test
// Drives load and advance transactions into the date core with random gaps
// on both channels and a long receiver hold-off. A scoreboard keeps its own
// copy of the calendar date and checks every result field by field.
// ----------------------------------------------------------------------------
module calendar_date_advance_core_test;
    import cda_pkg::*;

    localparam int  LIMIT_CYCLES    = 600000;
    localparam int  HOLD_OFF_CYCLES = 300;
    localparam int  DRAIN_CYCLES    = 20;
    localparam int  RANDOM_ITEMS    = 230;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic        leap;
    } cal_date_t;

    class date_scoreboard;
        logic [4:0]  held_day   = DAY_FIRST;
        logic [3:0]  held_month = MONTH_JAN;
        logic [15:0] held_year  = 16'd0;
        cal_date_t   expected_dates[$];
        int          mismatches = 0;

        function bit leap_of(input logic [15:0] y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        function logic [4:0] days_in_month(input logic [3:0] m, input logic [15:0] y);
            if (m == MONTH_FEB)
                return leap_of(y) ? DAYS_29 : DAYS_28;
            if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
                return DAYS_30;
            return DAYS_31;
        endfunction

        // Walk forward: whole years from January 1st, otherwise month by month.
        function void add_days(input int unsigned n);
            int unsigned left;
            int unsigned ylen;
            int unsigned len;
            int unsigned room;
            int unsigned stride;
            left = n;
            while (left > 0)
            begin
                if (held_day == DAY_FIRST && held_month == MONTH_JAN)
                begin
                    ylen = leap_of(held_year) ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
                    if (left >= ylen)
                    begin
                        left -= ylen;
                        held_year = held_year + 16'd1;
                        continue;
                    end
                end
                len = days_in_month(held_month, held_year);
                if (held_day < len)
                begin
                    room = len - held_day;
                    stride = (left < room) ? left : room;
                    held_day = held_day + 5'(stride);
                    left -= stride;
                end
                else
                begin
                    // Also covers a loaded day past the month end
                    held_day = DAY_FIRST;
                    left -= 1;
                    if (held_month >= MONTH_DEC)
                    begin
                        held_month = MONTH_JAN;
                        held_year = held_year + 16'd1;
                    end
                    else
                        held_month = held_month + 4'd1;
                end
            end
        endfunction

        function void note_transaction(input logic item_mode, input logic [4:0] d,
                                       input logic [3:0] m, input logic [15:0] y,
                                       input logic [15:0] count);
            cal_date_t next_date;
            if (item_mode == MODE_LOAD)
            begin
                held_day   = (d == 5'd0) ? DAY_FIRST : d;
                held_month = (m == 4'd0) ? MONTH_JAN : ((m > MONTH_DEC) ? MONTH_DEC : m);
                held_year  = y;
            end
            else
                add_days(count);
            next_date.day   = held_day;
            next_date.month = held_month;
            next_date.year  = held_year;
            next_date.leap  = leap_of(held_year);
            expected_dates.push_back(next_date);
        endfunction

        function void check_result(input cal_date_t got);
            cal_date_t want;
            if (expected_dates.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result %0d/%0d/%0d leap %0b",
                             got.day, got.month, got.year, got.leap);
                mismatches++;
                return;
            end
            want = expected_dates.pop_front();
            if (got !== want)
            begin
                if (mismatches < 10)
                    $display("date mismatch: expected %0d/%0d/%0d leap %0b, got %0d/%0d/%0d leap %0b",
                             want.day, want.month, want.year, want.leap,
                             got.day, got.month, got.year, got.leap);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [15:0] new_year;
    logic [15:0] day_count;
    logic        out_valid;
    logic        out_ready;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        leap_year;

    date_scoreboard sb = new();
    int             cycles       = 0;
    int             results_seen = 0;
    bit             held_off     = 1'b0;
    bit             burst        = 1'b0;
    int             pick;

    calendar_date_advance_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .new_day   (new_day),
        .new_month (new_month),
        .new_year  (new_year),
        .day_count (day_count),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .day       (day),
        .month     (month),
        .year      (year),
        .leap_year (leap_year)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result('{day, month, year, leap_year});
            results_seen++;
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic [15:0] pick_year();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'(100 * $urandom_range(0, 655));
            2: return 16'(400 * $urandom_range(0, 163));
            3: return 16'(65535 - $urandom_range(0, 3));
            default: return 16'($urandom_range(1890, 2110));
        endcase
    endfunction

    function logic [15:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 16'($urandom_range(0, 40));
        if (r < 82)
            return 16'($urandom_range(41, 400));
        if (r < 94)
            return 16'($urandom_range(401, 5000));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_item(input logic item_mode, input logic [4:0] d,
                             input logic [3:0] m, input logic [15:0] y,
                             input logic [15:0] count);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= item_mode;
        new_day   <= d;
        new_month <= m;
        new_year  <= y;
        day_count <= count;
        do @(posedge clk); while (!in_ready);
        sb.note_transaction(item_mode, d, m, y, count);
    endtask

    task automatic send_random_item();
        logic [4:0] d;
        logic [3:0] m;
        if ($urandom_range(0, 99) < 30)
        begin
            if ($urandom_range(0, 99) < 80)
                d = 5'($urandom_range(0, 1) ? $urandom_range(1, 28) : $urandom_range(27, 31));
            else
                d = 5'($urandom_range(0, 31));
            m = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 12))
                                             : 4'($urandom_range(0, 15));
            send_item(MODE_LOAD, d, m, pick_year(), 16'($urandom_range(0, 65535)));
        end
        else
            send_item(MODE_ADVANCE, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                      16'($urandom_range(0, 65535)), pick_count());
    endtask

    // Receiver: random ready pattern, one long hold-off once traffic is flowing
    initial
    begin
        out_ready <= 1'b0;
        repeat (4) @(posedge clk);
        forever
        begin
            if (!held_off && results_seen >= 40)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
                else if (pick < 65)
                begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(50, 150)) @(posedge clk);
                end
                else if (pick < 92)
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(15, 50)) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        mode      <= MODE_LOAD;
        new_day   <= 5'd0;
        new_month <= 4'd0;
        new_year  <= 16'd0;
        day_count <= 16'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset date, clamping, month ends, leap rules, year wrap
        send_item(MODE_ADVANCE, 5'd31, 4'd15, 16'hFFFF, 16'd0);
        send_item(MODE_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd1);
        send_item(MODE_LOAD, 5'd0, 4'd0, 16'd0, 16'hFFFF);
        send_item(MODE_LOAD, 5'd31, 4'd15, 16'hFFFF, 16'd0);
        send_item(MODE_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd1);
        send_item(MODE_LOAD, 5'd29, MONTH_FEB, 16'd2000, 16'd0);
        send_item(MODE_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd1);
        send_item(MODE_LOAD, 5'd28, MONTH_FEB, 16'd1900, 16'd0);
        send_item(MODE_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd1);
        send_item(MODE_LOAD, 5'd28, MONTH_FEB, 16'd2004, 16'd0);
        send_item(MODE_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd1);
        send_item(MODE_LOAD, 5'd31, MONTH_FEB, 16'd2023, 16'd0);
        send_item(MODE_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd0);
        send_item(MODE_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd1);
        send_item(MODE_LOAD, 5'd31, MONTH_APR, 16'd2021, 16'd0);
        send_item(MODE_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd1);
        send_item(MODE_LOAD, 5'd1, MONTH_JAN, 16'd1999, 16'd0);
        send_item(MODE_ADVANCE, 5'd0, 4'd0, 16'd0, 16'hFFFF);
        send_item(MODE_LOAD, 5'd0, 4'd13, 16'd65000, 16'd0);
        send_item(MODE_ADVANCE, 5'd0, 4'd0, 16'd0, 16'hFFFF);
        send_item(MODE_LOAD, 5'd31, 4'd14, 16'd65534, 16'd0);
        send_item(MODE_ADVANCE, 5'd31, 4'd15, 16'hFFFF, 16'h8000);
        send_item(MODE_LOAD, 5'd1, MONTH_JAN, 16'd2400, 16'd0);
        send_item(MODE_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd366);

        // Random: blocks of 25 items, each with or without sender gaps at random
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 25 == 0)
                burst = ($urandom_range(0, 3) == 0);
            send_random_item();
        end
        in_valid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
